>>> rtl/sioreg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sioreg_pkg
// Types, port addresses and constants shared by the I/O register bank.
// ----------------------------------------------------------------------------
package sioreg_pkg;

	// bus access kind carried in the slave-side tuser
	typedef enum logic [0:0] {
		FUNC_READ  = 1'b0,
		FUNC_WRITE = 1'b1
	} func_t;

	// chip generations selected by the chip_model register
	localparam logic [1:0] CHIP_GEN1      = 2'd0;
	localparam logic [1:0] CHIP_GEN2      = 2'd1;
	localparam logic [1:0] CHIP_GEN2_REV2 = 2'd2;
	// spare code, decodes as second generation
	localparam logic [1:0] CHIP_SPARE     = 2'd3;

	// configuration register word index (paddr[2])
	localparam logic CFG_IDX_CHIP_MODEL = 1'b0;

	// I/O port addresses
	localparam logic [15:0] ADDR_DMA_SRC0  = 16'h0040;
	localparam logic [15:0] ADDR_DMA_SRC1  = 16'h0041;
	localparam logic [15:0] ADDR_DMA_SRC2  = 16'h0042;
	localparam logic [15:0] ADDR_DMA_TGT0  = 16'h0044;
	localparam logic [15:0] ADDR_DMA_TGT1  = 16'h0045;
	localparam logic [15:0] ADDR_DMA_LEN0  = 16'h0046;
	localparam logic [15:0] ADDR_DMA_LEN1  = 16'h0047;
	localparam logic [15:0] ADDR_DMA_CTRL  = 16'h0048;
	localparam logic [15:0] ADDR_POWER     = 16'h0062;
	localparam logic [15:0] ADDR_CART      = 16'h00a0;
	localparam logic [15:0] ADDR_IRQ_BASE  = 16'h00b0;
	localparam logic [15:0] ADDR_IRQ_EN    = 16'h00b2;
	localparam logic [15:0] ADDR_IRQ_STAT  = 16'h00b4;
	localparam logic [15:0] ADDR_KEYPAD    = 16'h00b5;
	localparam logic [15:0] ADDR_IRQ_ACK   = 16'h00b6;
	localparam logic [15:0] ADDR_NMI_CTRL  = 16'h00b7;

	// status bits that an acknowledge write may clear (edge-triggered sources)
	localparam logic [7:0] ACK_EDGE_MASK = 8'b1111_0010;

	// base masks per generation
	localparam logic [7:0] BASE_MASK_GEN1 = 8'hf8;
	localparam logic [7:0] BASE_MASK_GEN2 = 8'hfe;
	localparam logic [7:0] BASE_RD_GEN1   = 8'h03;

	typedef struct packed {
		logic [7:0]  irq_raise;
		logic [3:0]  key_lines;
		logic [7:0]  write_data;
		logic [15:0] address;
		func_t       func;
	} item_t;

	typedef struct packed {
		logic [7:0]  irq_base_out;
		logic [7:0]  irq_enabled;
		logic [7:0]  irq_pending;
		logic        dma_dir_out;
		logic [15:0] dma_length_out;
		logic [15:0] dma_target_out;
		logic [23:0] dma_source_out;
		logic        power_off;
		logic        dma_start;
		logic [7:0]  read_data;
	} result_t;

	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 96;
	localparam int unsigned RESULT_W    = $bits(result_t);

endpackage

>>> rtl/sioreg_apb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sioreg_apb
// APB slave holding the chip model register.
// ----------------------------------------------------------------------------
module sioreg_apb (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [1:0]  chip_model
);

	logic [1:0] chip_model_q;
	logic       wr_en;
	logic       hit;

	assign pready = 1'b1;
	assign hit    = (paddr[2] == sioreg_pkg::CFG_IDX_CHIP_MODEL);
	assign wr_en  = psel && penable && pwrite && pready && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_model_q <= sioreg_pkg::CHIP_GEN1;
		end else if (wr_en) begin
			chip_model_q <= pwdata[1:0];
		end
	end

	assign prdata     = hit ? {30'd0, chip_model_q} : 32'd0;
	assign chip_model = chip_model_q;

endmodule

>>> rtl/sioreg_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sioreg_core
// Port decode and register state; forms the result word of one access.
// ----------------------------------------------------------------------------
module sioreg_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  sioreg_pkg::item_t   item,
	input  logic [1:0]          chip_model,
	output sioreg_pkg::result_t result
);

	logic [23:0] dma_src_q, dma_src_n;
	logic [15:0] dma_tgt_q, dma_tgt_n;
	logic [15:0] dma_len_q, dma_len_n;
	logic        dma_dir_q, dma_dir_n;
	logic        dma_en_q, dma_en_n;
	logic        cart_en_q, cart_en_n;
	logic        cart_width_q, cart_width_n;
	logic        cart_wait_q, cart_wait_n;
	logic [7:0]  irq_base_q, irq_base_n;
	logic [7:0]  irq_en_q, irq_en_n;
	logic [7:0]  irq_stat_q, irq_stat_n;
	logic [2:0]  key_mtx_q, key_mtx_n;
	logic        nmi_lowbat_q, nmi_lowbat_n;
	logic [7:0]  rd;
	logic        start;
	logic        poff;
	logic        gen1;
	logic [7:0]  d;

	assign gen1 = (chip_model == sioreg_pkg::CHIP_GEN1);
	assign d    = item.write_data;

	always_comb begin
		dma_src_n    = dma_src_q;
		dma_tgt_n    = dma_tgt_q;
		dma_len_n    = dma_len_q;
		dma_dir_n    = dma_dir_q;
		dma_en_n     = dma_en_q;
		cart_en_n    = cart_en_q;
		cart_width_n = cart_width_q;
		cart_wait_n  = cart_wait_q;
		irq_base_n   = irq_base_q;
		irq_en_n     = irq_en_q;
		irq_stat_n   = irq_stat_q;
		key_mtx_n    = key_mtx_q;
		nmi_lowbat_n = nmi_lowbat_q;
		rd           = 8'd0;
		start        = 1'b0;
		poff         = 1'b0;
		if (item.func == sioreg_pkg::FUNC_WRITE) begin
			case (item.address)
				sioreg_pkg::ADDR_DMA_SRC0: dma_src_n[7:0]   = {d[7:1], 1'b0};
				sioreg_pkg::ADDR_DMA_SRC1: dma_src_n[15:8]  = d;
				sioreg_pkg::ADDR_DMA_SRC2: dma_src_n[23:16] = d;
				sioreg_pkg::ADDR_DMA_TGT0: dma_tgt_n[7:0]   = {d[7:1], 1'b0};
				sioreg_pkg::ADDR_DMA_TGT1: dma_tgt_n[15:8]  = d;
				sioreg_pkg::ADDR_DMA_LEN0: dma_len_n[7:0]   = {d[7:1], 1'b0};
				sioreg_pkg::ADDR_DMA_LEN1: dma_len_n[15:8]  = d;
				sioreg_pkg::ADDR_DMA_CTRL: begin
					dma_dir_n = d[6];
					dma_en_n  = d[7];
					start     = d[7];
				end
				sioreg_pkg::ADDR_POWER: poff = !gen1 && d[0];
				sioreg_pkg::ADDR_CART: begin
					// enable is sticky: set only, never cleared by software
					cart_en_n    = cart_en_q | d[0];
					cart_width_n = d[2];
					cart_wait_n  = d[3];
				end
				sioreg_pkg::ADDR_IRQ_BASE: irq_base_n = d & (gen1 ?
					sioreg_pkg::BASE_MASK_GEN1 : sioreg_pkg::BASE_MASK_GEN2);
				sioreg_pkg::ADDR_IRQ_EN:   irq_en_n   = d;
				sioreg_pkg::ADDR_KEYPAD:   key_mtx_n  = d[6:4];
				sioreg_pkg::ADDR_IRQ_ACK:  irq_stat_n = irq_stat_q &
					~(d & sioreg_pkg::ACK_EDGE_MASK);
				sioreg_pkg::ADDR_NMI_CTRL: nmi_lowbat_n = d[4];
				default: ;
			endcase
		end else begin
			case (item.address)
				sioreg_pkg::ADDR_DMA_SRC0: rd = dma_src_q[7:0];
				sioreg_pkg::ADDR_DMA_SRC1: rd = dma_src_q[15:8];
				sioreg_pkg::ADDR_DMA_SRC2: rd = dma_src_q[23:16];
				sioreg_pkg::ADDR_DMA_TGT0: rd = dma_tgt_q[7:0];
				sioreg_pkg::ADDR_DMA_TGT1: rd = dma_tgt_q[15:8];
				sioreg_pkg::ADDR_DMA_LEN0: rd = dma_len_q[7:0];
				sioreg_pkg::ADDR_DMA_LEN1: rd = dma_len_q[15:8];
				sioreg_pkg::ADDR_DMA_CTRL: rd = {dma_en_q, 6'd0, dma_dir_q};
				sioreg_pkg::ADDR_POWER:
					rd = {(chip_model == sioreg_pkg::CHIP_GEN2_REV2), 7'd0};
				sioreg_pkg::ADDR_CART:
					rd = {1'b1, 3'd0, cart_wait_q, cart_width_q, !gen1, cart_en_q};
				sioreg_pkg::ADDR_IRQ_BASE:
					rd = irq_base_q | (gen1 ? sioreg_pkg::BASE_RD_GEN1 : 8'd0);
				sioreg_pkg::ADDR_IRQ_EN:   rd = irq_en_q;
				sioreg_pkg::ADDR_IRQ_STAT: rd = irq_stat_q;
				sioreg_pkg::ADDR_KEYPAD:   rd = {1'b0, key_mtx_q, item.key_lines};
				sioreg_pkg::ADDR_NMI_CTRL: rd = {3'd0, nmi_lowbat_q, 4'd0};
				default: ;
			endcase
		end
		// raised lines land after the access, so they survive an acknowledge
		irq_stat_n = irq_stat_n | item.irq_raise;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dma_src_q    <= '0;
			dma_tgt_q    <= '0;
			dma_len_q    <= '0;
			dma_dir_q    <= 1'b0;
			dma_en_q     <= 1'b0;
			cart_en_q    <= 1'b0;
			cart_width_q <= 1'b0;
			cart_wait_q  <= 1'b0;
			irq_base_q   <= '0;
			irq_en_q     <= '0;
			irq_stat_q   <= '0;
			key_mtx_q    <= '0;
			nmi_lowbat_q <= 1'b0;
		end else if (commit) begin
			dma_src_q    <= dma_src_n;
			dma_tgt_q    <= dma_tgt_n;
			dma_len_q    <= dma_len_n;
			dma_dir_q    <= dma_dir_n;
			dma_en_q     <= dma_en_n;
			cart_en_q    <= cart_en_n;
			cart_width_q <= cart_width_n;
			cart_wait_q  <= cart_wait_n;
			irq_base_q   <= irq_base_n;
			irq_en_q     <= irq_en_n;
			irq_stat_q   <= irq_stat_n;
			key_mtx_q    <= key_mtx_n;
			nmi_lowbat_q <= nmi_lowbat_n;
		end
	end

	always_comb begin
		result.read_data      = rd;
		result.dma_start      = start;
		result.power_off      = poff;
		result.dma_source_out = dma_src_n;
		result.dma_target_out = dma_tgt_n;
		result.dma_length_out = dma_len_n;
		result.dma_dir_out    = dma_dir_n;
		result.irq_pending    = irq_stat_n;
		result.irq_enabled    = irq_en_n;
		result.irq_base_out   = irq_base_n;
	end

	// state moves only when a word is committed
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable({dma_src_q, dma_tgt_q, dma_len_q, irq_stat_q, irq_en_q,
			irq_base_q, cart_en_q, key_mtx_q}))
		else $error("register state changed without a committed access");

	a_cart_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		cart_en_q |=> cart_en_q)
		else $error("cartridge enable cleared");

	a_start_enable: assert property (@(posedge clk) disable iff (!arst_n)
		commit && result.dma_start |=> dma_en_q)
		else $error("dma start without enable stored");

	a_poff_gen: assert property (@(posedge clk) disable iff (!arst_n)
		result.power_off |-> !gen1 && item.func == sioreg_pkg::FUNC_WRITE)
		else $error("power-off pulse on first-generation chip or read");

	a_even_addr: assert property (@(posedge clk) disable iff (!arst_n)
		!dma_src_q[0] && !dma_tgt_q[0] && !dma_len_q[0] && !irq_base_q[0])
		else $error("dma address, length or base bit 0 set");

endmodule

>>> rtl/soc_io_register_bank_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soc_io_register_bank_unit
// Byte-wide I/O register bank: one bus access per word in, one result out.
// ----------------------------------------------------------------------------
// Each slave-side word is one port access (tuser: read or write). The word
// is taken into an input register; as it advances, the port decode reads
// and updates the register state and the result goes to the output
// register, from which the master side presents it.
// Throughput: one access per cycle unless the master side stalls, set by
// the single decode and update step between input and output registers.
// While the master side is stalled, the output register holds its word; the
// input register may still take one more word, then tready drops until the
// output drains. State is committed only as a word moves into the output
// register, so accesses take effect strictly in order. Reset clears all
// bank registers, the chip model (first generation) and both valid flags;
// the user writes the chip model over APB only while idle (not enforced).
// ----------------------------------------------------------------------------
module soc_io_register_bank_unit (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// address[15:0], write_data[23:16], key_lines[27:24], irq_raise[35:28]
	input  logic [sioreg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// func[0]
	input  logic [0:0]  s_axis_tuser,
	// master side
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data[7:0], dma_start[8], power_off[9], dma_source_out[33:10],
	// dma_target_out[49:34], dma_length_out[65:50], dma_dir_out[66],
	// irq_pending[74:67], irq_enabled[82:75], irq_base_out[90:83]
	output logic [sioreg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	sioreg_pkg::item_t   item_s1;
	logic                valid_s1;
	sioreg_pkg::result_t res_s2;
	sioreg_pkg::result_t res_comb;
	logic                valid_s2;
	logic                advance;
	logic [1:0]          chip_model;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.func       <= sioreg_pkg::func_t'(s_axis_tuser[0]);
			item_s1.address    <= s_axis_tdata[15:0];
			item_s1.write_data <= s_axis_tdata[23:16];
			item_s1.key_lines  <= s_axis_tdata[27:24];
			item_s1.irq_raise  <= s_axis_tdata[35:28];
		end
	end

	sioreg_apb u_apb (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.chip_model (chip_model)
	);

	sioreg_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.commit     (advance),
		.item       (item_s1),
		.chip_model (chip_model),
		.result     (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// hold the result word until the master side takes it
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {
		(sioreg_pkg::OUT_TDATA_W - sioreg_pkg::RESULT_W)'(0),
		res_s2
	};

endmodule
